@@ rtl/core/sws_pkg.sv @@
`timescale 1ns / 1ps

package sws_pkg;

    // Stream constants
    localparam logic [7:0] SPACE_BYTE   = 8'd32;
    localparam int         BUF_DEPTH    = 63;
    localparam int         CNT_W        = 6;
    localparam logic [CNT_W-1:0] MIN_LEN_RESET = 6'd1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Input word and result word
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out_word;

    // Commands from the classifier to the emitter
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_FLUSH,
        CMD_END
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] count;
        logic             sep;
    } t_cmd;

    // Write port into the word buffer
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } t_buf_wr;

    // Emitter states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEP,
        ST_FLUSH
    } t_back_state;

endpackage

@@ rtl/core/sws_queue.sv @@
`timescale 1ns / 1ps

module sws_queue import sws_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/core/sws_front.sv @@
`timescale 1ns / 1ps

module sws_front import sws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_word         i_word,
    output logic             o_push,
    output t_cmd             o_cmd,
    input  logic             i_full,
    output t_buf_wr          o_buf_wr,
    input  logic             i_flush_done
);

    logic [CNT_W-1:0] r_min_len, n_min_len;
    logic [CNT_W-1:0] r_pending, n_pending;
    logic             r_passing, n_passing;
    logic             r_any_kept, n_any_kept;
    logic             r_busy, n_busy;

    logic             accept;
    logic [CNT_W-1:0] cnt_next;

    // Stall while the queue is full or a buffer flush is still being read out
    assign o_ready     = !i_full && !r_busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign cnt_next    = r_pending + 1'b1;

    // Classify the word and update word tracking
    always_comb begin
        n_min_len  = r_min_len;
        n_pending  = r_pending;
        n_passing  = r_passing;
        n_any_kept = r_any_kept;
        n_busy     = r_busy;
        o_push     = 1'b0;
        o_cmd      = '0;
        o_buf_wr   = '0;

        if (i_cfg_valid) begin
            n_min_len = i_cfg_data;
        end

        if (i_flush_done) begin
            n_busy = 1'b0;
        end

        if (accept) begin
            if (i_word.end_of_text) begin
                o_push       = 1'b1;
                o_cmd.kind   = CMD_END;
                n_pending    = '0;
                n_passing    = 1'b0;
                n_any_kept   = 1'b0;
            end else if (i_word.text_byte == SPACE_BYTE) begin
                n_pending = '0;
                n_passing = 1'b0;
            end else if (r_passing) begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_BYTE;
                o_cmd.data = i_word.text_byte;
            end else begin
                o_buf_wr.en   = 1'b1;
                o_buf_wr.addr = r_pending;
                o_buf_wr.data = i_word.text_byte;
                // A minimum of zero keeps every word, same as one
                if (cnt_next >= r_min_len) begin
                    o_push      = 1'b1;
                    o_cmd.kind  = CMD_FLUSH;
                    o_cmd.count = cnt_next;
                    o_cmd.sep   = r_any_kept;
                    n_pending   = '0;
                    n_passing   = 1'b1;
                    n_any_kept  = 1'b1;
                    n_busy      = 1'b1;
                end else begin
                    n_pending = cnt_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len  <= MIN_LEN_RESET;
            r_pending  <= '0;
            r_passing  <= 1'b0;
            r_any_kept <= 1'b0;
            r_busy     <= 1'b0;
        end else begin
            r_min_len  <= n_min_len;
            r_pending  <= n_pending;
            r_passing  <= n_passing;
            r_any_kept <= n_any_kept;
            r_busy     <= n_busy;
        end
    end

endmodule

@@ rtl/core/sws_back.sv @@
`timescale 1ns / 1ps

module sws_back import sws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_valid,
    output logic      o_pop,
    input  t_buf_wr   i_buf_wr,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word,
    output logic      o_flush_done
);

    logic [7:0]       r_buf [BUF_DEPTH];
    logic [7:0]       r_rd_data;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    t_back_state      r_state, n_state;
    logic             r_out_vld;
    t_out_word        r_out;

    logic             load_ok;
    logic             emit;
    t_out_word        emit_word;
    logic [CNT_W-1:0] idx_inc;
    logic             flush_last;

    assign load_ok    = !r_out_vld || i_ready;
    assign idx_inc    = r_idx + 1'b1;
    assign flush_last = (idx_inc == r_count);
    assign o_valid    = r_out_vld;
    assign o_word     = r_out;

    // Word buffer: written by the front, read one entry per cycle here while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (i_buf_wr.en) begin
            r_buf[i_buf_wr.addr] <= i_buf_wr.data;
        end
        r_rd_data <= r_buf[n_idx];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && load_ok && i_cmd.kind == CMD_FLUSH) begin
                    n_state = i_cmd.sep ? ST_SEP : ST_FLUSH;
                end
            end
            ST_SEP: begin
                if (load_ok) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (load_ok && flush_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs, read index and flush length
    always_comb begin
        o_pop        = 1'b0;
        emit         = 1'b0;
        emit_word    = '0;
        n_idx        = r_idx;
        n_count      = r_count;
        o_flush_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (i_cmd_valid && load_ok) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_BYTE: begin
                            emit      = 1'b1;
                            emit_word = '{out_byte: i_cmd.data, out_valid: 1'b1,
                                          out_last: 1'b0};
                        end
                        CMD_END: begin
                            emit      = 1'b1;
                            emit_word = '{out_byte: 8'd0, out_valid: 1'b0,
                                          out_last: 1'b1};
                        end
                        CMD_FLUSH: begin
                            n_count = i_cmd.count;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEP: begin
                n_idx = '0;
                if (load_ok) begin
                    emit      = 1'b1;
                    emit_word = '{out_byte: SPACE_BYTE, out_valid: 1'b1, out_last: 1'b0};
                end
            end
            ST_FLUSH: begin
                if (load_ok) begin
                    emit      = 1'b1;
                    emit_word = '{out_byte: r_rd_data, out_valid: 1'b1, out_last: 1'b0};
                    if (flush_last) begin
                        n_idx        = '0;
                        o_flush_done = 1'b1;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_word;
        end
    end

endmodule

@@ rtl/core/short_word_stream_filter.sv @@
`timescale 1ns / 1ps

// Short-word stream filter.
// Input channel (i_valid/o_ready, i_word) takes one text byte per word, or
// an end-of-text marker. Output channel (o_valid/i_ready, o_word) delivers
// the filtered text: kept words separated by one space, then one terminator
// word with out_last set and out_valid clear.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_data) sets the minimum
// word length; it is always ready and should be written while idle.
// A pass-through byte is accepted into the command queue and from there
// loaded into the output register. When a word reaches the minimum length,
// the front pushes a flush of n buffered bytes; the back takes the command,
// then sends the separating space if one is due and reads the word buffer
// one entry per cycle while the output register can take it. The input
// stalls until the last buffered byte has been loaded into the output
// register. Otherwise one byte per cycle is accepted, limited by the
// 4-entry queue.
// Reset clears all word tracking and the queue; the minimum length goes
// to 1. When the receiver stalls, the output register holds, the queue
// fills and the input ready drops.

module short_word_stream_filter import sws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_word         i_word,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_word        o_word
);

    logic    q_push;
    t_cmd    q_in;
    logic    q_full;
    logic    q_pop;
    t_cmd    q_out;
    logic    q_empty;
    t_buf_wr buf_wr;
    logic    flush_done;

    sws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_word       (i_word),
        .o_push       (q_push),
        .o_cmd        (q_in),
        .i_full       (q_full),
        .o_buf_wr     (buf_wr),
        .i_flush_done (flush_done)
    );

    sws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    sws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_out),
        .i_cmd_valid  (!q_empty),
        .o_pop        (q_pop),
        .i_buf_wr     (buf_wr),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word       (o_word),
        .o_flush_done (flush_done)
    );

    // No command is pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // No command is popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // The buffer is not written in the cycle the last byte of a flush is read out
    a_no_wr_during_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush_done |-> !buf_wr.en)
        else $error("word buffer written during flush");

    // The terminator carries no character
    a_term_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.out_last) |-> (!o_word.out_valid && o_word.out_byte == 8'd0))
        else $error("terminator carries a character");

endmodule

@@ tb/sv/tb_short_word_stream_filter.sv @@
`timescale 1ns / 1ps

module tb_short_word_stream_filter;
    import sws_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 410;
    // quiet time before a config write, covers the pipe plus queue
    localparam int CFG_SETTLE   = 16;
    localparam int DRAIN_CYCLES = 20;
    // longest legal quiet stretch is the longest receiver stall or input gap
    localparam int IDLE_LIMIT   = 1000;
    localparam int MAX_REPORTS  = 40;
    localparam int DIR_ROWS     = 27;

    typedef enum logic {
        ROW_TEXT,
        ROW_CFG
    } t_row_kind;

    // One directed step: a text word or a min-length write.
    // typed rows carry the single result they must produce.
    typedef struct packed {
        t_row_kind        kind;
        t_in_word         word;
        logic [CNT_W-1:0] cfg;
        logic             typed;
        t_out_word        want;
    } t_stim_row;

    localparam t_out_word NO_WORD   = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b0};
    localparam t_out_word TERM_WORD = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};

    // DUT ports
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data  = MIN_LEN_RESET;
    logic             i_valid     = 1'b0;
    logic             o_ready;
    t_in_word         i_word      = '0;
    logic             o_valid;
    logic             i_ready     = 1'b0;
    t_out_word        o_word;

    // Filter state mirrored by the predictor
    logic [CNT_W-1:0] min_len   = MIN_LEN_RESET;
    logic [7:0]       word_buf [BUF_DEPTH];
    int unsigned      held_cnt  = 0;
    bit               streaming = 1'b0;
    bit               word_seen = 1'b0;

    t_out_word   filtered_q [$];
    int unsigned err_count   = 0;
    int unsigned idle_cycles = 0;
    int unsigned rdy_left    = 0;

    short_word_stream_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        err_count++;
    endtask

    // Filter prediction for one accepted input word; push_en gates the results
    task automatic predict_filtered(input t_in_word w, input bit push_en);
        int unsigned need;
        // a minimum of zero keeps every word, same as one
        need = (min_len == 0) ? 1 : min_len;
        if (w.end_of_text) begin
            if (push_en) filtered_q.push_back(TERM_WORD);
            held_cnt  = 0;
            streaming = 1'b0;
            word_seen = 1'b0;
        end else if (w.text_byte == SPACE_BYTE) begin
            streaming = 1'b0;
            held_cnt  = 0;
        end else if (streaming) begin
            if (push_en) filtered_q.push_back(t_out_word'{w.text_byte, 1'b1, 1'b0});
        end else begin
            if (held_cnt < BUF_DEPTH) word_buf[held_cnt] = w.text_byte;
            held_cnt++;
            // word long enough: separator if a word was kept before, then the held bytes
            if (held_cnt >= need) begin
                if (push_en && word_seen) begin
                    filtered_q.push_back(t_out_word'{SPACE_BYTE, 1'b1, 1'b0});
                end
                for (int i = 0; i < held_cnt && i < BUF_DEPTH; i++) begin
                    if (push_en) filtered_q.push_back(t_out_word'{word_buf[i], 1'b1, 1'b0});
                end
                held_cnt  = 0;
                streaming = 1'b1;
                word_seen = 1'b1;
            end
        end
    endtask

    // Offer one input word, predict on acceptance, then maybe idle
    task automatic send_text(input t_in_word w, input bit typed, input t_out_word want);
        int unsigned r;
        int unsigned gap;
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (!o_ready);
        if (typed) filtered_q.push_back(want);
        predict_filtered(w, !typed);
        r = $urandom_range(0, 99);
        if (r < 65) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(15, 30);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Min-length write, only once the filter has gone quiet
    task automatic write_min_len(input logic [CNT_W-1:0] v);
        i_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        min_len = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver pacing: ready stretches and stalls of random length
    always @(posedge i_clk) begin : rx_pace
        int unsigned r;
        if (rdy_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                i_ready  <= 1'b1;
                rdy_left <= $urandom_range(1, 20);
            end else if (r < 60) begin
                i_ready  <= 1'b1;
                rdy_left <= $urandom_range(50, 200);
            end else if (r < 88) begin
                i_ready  <= 1'b0;
                rdy_left <= $urandom_range(1, 3);
            end else if (r < 97) begin
                i_ready  <= 1'b0;
                rdy_left <= $urandom_range(4, 10);
            end else begin
                i_ready  <= 1'b0;
                rdy_left <= $urandom_range(20, 40);
            end
        end else begin
            rdy_left <= rdy_left - 1;
        end
    end

    // Output check against the oldest expected word
    always @(posedge i_clk) begin : out_check
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_word));
            end else begin
                want = filtered_q.pop_front();
                if (o_word.out_byte !== want.out_byte) begin
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              o_word.out_byte, want.out_byte));
                end
                if (o_word.out_valid !== want.out_valid) begin
                    report_mismatch($sformatf("out_valid %b, want %b",
                                              o_word.out_valid, want.out_valid));
                end
                if (o_word.out_last !== want.out_last) begin
                    report_mismatch($sformatf("out_last %b, want %b",
                                              o_word.out_last, want.out_last));
                end
            end
        end
    end

    // Watchdog: no word moving on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_short_word_stream_filter failed");
            $finish;
        end
    end

    initial begin : stim
        t_stim_row   dir_rows [DIR_ROWS];
        t_in_word    w;
        int unsigned sent;
        int unsigned need;
        int unsigned n_words;
        int unsigned n_texts;
        int unsigned len;
        int unsigned r;
        int unsigned b;

        dir_rows = '{
            // terminator straight after reset
            '{ROW_TEXT, {8'h00, 1'b1}, 6'd0, 1'b1, TERM_WORD},
            // leading space, then a one-byte word kept at min 1
            '{ROW_TEXT, {SPACE_BYTE, 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"A", 1'b0}, 6'd0, 1'b1, {"A", 1'b1, 1'b0}},
            '{ROW_TEXT, {SPACE_BYTE, 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {SPACE_BYTE, 1'b0}, 6'd0, 1'b0, NO_WORD},
            // extreme byte values
            '{ROW_TEXT, {8'hFF, 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {8'h00, 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {8'hFF, 1'b1}, 6'd0, 1'b1, TERM_WORD},
            // min 3: short word dropped, longer words flushed then streamed
            '{ROW_CFG, {8'h00, 1'b0}, 6'd3, 1'b0, NO_WORD},
            '{ROW_TEXT, {"a", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"b", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {SPACE_BYTE, 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"c", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"d", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"e", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"f", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {SPACE_BYTE, 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"g", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"h", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"i", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {SPACE_BYTE, 1'b1}, 6'd0, 1'b1, TERM_WORD},
            // min 0 keeps every word
            '{ROW_CFG, {8'h00, 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {"q", 1'b0}, 6'd0, 1'b1, {"q", 1'b1, 1'b0}},
            '{ROW_TEXT, {8'h00, 1'b1}, 6'd0, 1'b1, TERM_WORD},
            // min 63: held short word dropped at the end marker
            '{ROW_CFG, {8'h00, 1'b0}, 6'd63, 1'b0, NO_WORD},
            '{ROW_TEXT, {"z", 1'b0}, 6'd0, 1'b0, NO_WORD},
            '{ROW_TEXT, {8'h5A, 1'b1}, 6'd0, 1'b1, TERM_WORD}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_min_len(dir_rows[k].cfg);
            end else begin
                send_text(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        // random phases: new min length, then a few texts
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) write_min_len(6'd0);
            else if (r < 22) write_min_len(6'd63);
            else if (r < 32) write_min_len(6'd1);
            else if (r < 45) write_min_len(6'($urandom_range(1, 63)));
            else write_min_len(6'($urandom_range(2, 8)));
            need = (min_len == 0) ? 1 : min_len;

            n_texts = $urandom_range(1, 3);
            for (int t = 0; t < n_texts && sent < RANDOM_ITEMS; t++) begin
                if ($urandom_range(0, 99) < 15) begin
                    // noise: any byte, spaces frequent
                    repeat ($urandom_range(3, 40)) begin
                        b = $urandom_range(0, 255);
                        w.end_of_text = 1'b0;
                        w.text_byte   = ($urandom_range(0, 3) == 0) ? SPACE_BYTE : b[7:0];
                        send_text(w, 1'b0, NO_WORD);
                        sent++;
                    end
                end else begin
                    // well-formed text, word lengths clustered around the minimum
                    w = '{text_byte: SPACE_BYTE, end_of_text: 1'b0};
                    if ($urandom_range(0, 4) == 0) begin
                        repeat ($urandom_range(1, 2)) begin
                            send_text(w, 1'b0, NO_WORD);
                            sent++;
                        end
                    end
                    n_words = (need > 16) ? $urandom_range(1, 3) : $urandom_range(1, 6);
                    for (int k = 0; k < n_words && sent < RANDOM_ITEMS; k++) begin
                        if (k > 0) begin
                            w = '{text_byte: SPACE_BYTE, end_of_text: 1'b0};
                            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1) begin
                                send_text(w, 1'b0, NO_WORD);
                                sent++;
                            end
                        end
                        r = $urandom_range(0, 99);
                        if (r < 60) len = $urandom_range((need > 2) ? need - 2 : 1, need + 3);
                        else if (r < 85) len = $urandom_range(1, need);
                        else len = $urandom_range(need, need + 20);
                        repeat (len) begin
                            do b = $urandom_range(0, 255); while (b == SPACE_BYTE);
                            w = '{text_byte: b[7:0], end_of_text: 1'b0};
                            send_text(w, 1'b0, NO_WORD);
                            sent++;
                        end
                    end
                    w = '{text_byte: SPACE_BYTE, end_of_text: 1'b0};
                    if ($urandom_range(0, 4) == 0) begin
                        repeat ($urandom_range(1, 2)) begin
                            send_text(w, 1'b0, NO_WORD);
                            sent++;
                        end
                    end
                end
                // end marker, its byte is don't-care
                b = $urandom_range(0, 255);
                w = '{text_byte: b[7:0], end_of_text: 1'b1};
                send_text(w, 1'b0, NO_WORD);
                sent++;
            end
        end

        // drain
        i_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_short_word_stream_filter passed");
        end else begin
            $display("tb_short_word_stream_filter failed");
        end
        $finish;
    end

endmodule
